[hw/rtl/dwis_pkg.sv]
// Package for the deque core: command and status codes, the word types of both channels,
// and the operation code of one storage cell.
// It has no dependencies and is compiled first.
package dwis_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_SEARCH     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_RANGE     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_FROM_LEFT  = 2'd2,
    OP_FROM_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]   found_position;
    logic [OCC_W-1:0]   occupancy;
  } out_word_t;

endpackage

[hw/rtl/dwis_cell.sv]
// One storage cell of the deque chain: holds one word and takes a new one from
// the load input or from either neighbor. Depends on dwis_pkg.
module dwis_cell import dwis_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_op_e              op_i,
  input  logic [WORD_WIDTH-1:0] load_i,
  input  logic [WORD_WIDTH-1:0] left_i,
  input  logic [WORD_WIDTH-1:0] right_i,
  output logic [WORD_WIDTH-1:0] data_o
);

  logic [WORD_WIDTH-1:0] data_q;
  logic [WORD_WIDTH-1:0] data_d;

  always_comb begin
    unique case (op_i)
      OP_HOLD:       data_d = data_q;
      OP_LOAD:       data_d = load_i;
      OP_FROM_LEFT:  data_d = left_i;
      OP_FROM_RIGHT: data_d = right_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[hw/rtl/deque_with_index_and_search_core.sv]
// Top level of the bounded double-ended queue with read by position and search.
// Depends on dwis_pkg and dwis_cell.
//
// Usage: one command word enters on in_valid_i/in_ready_o and one result word
// leaves on out_valid_o/out_ready_i for every command. The words are held in a
// row of DEPTH cells with the front word in cell zero. Pushes and pops shift or
// load the cells (a pop at the back only lowers the count) in the cycle the
// command is accepted, and their result is valid in the next cycle. A read in
// range and every search rotate the whole ring once through cell zero, one
// cell per cycle, which restores the order; S_DONE then loads their result
// into the output register once it is free. The rotation sets the throughput
// of these two commands; a read out of range or an unused command code skips it.
// A new command is taken only when no rotation is running and the output
// register is free or being emptied in the same cycle. When the receiver stalls,
// the result stays in the output register and further commands wait.
// Reset empties the queue and drops any pending result; the cell contents are
// not cleared and are never read before they are written.
module deque_with_index_and_search_core import dwis_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         step_q, step_d;
  logic                  is_search_q, is_search_d;
  logic                  found_q, found_d;
  logic [WORD_WIDTH-1:0] key_q, key_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [IW-1:0]         hit_idx_q, hit_idx_d;
  logic [WORD_WIDTH-1:0] hit_word_q, hit_word_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;

  logic                  in_fire;
  logic                  res_load;
  logic                  load_back;
  logic                  shift_right;
  logic                  shift_left;
  logic                  full;
  logic                  empty;
  logic                  in_range;
  logic                  step_last;
  logic                  step_held;
  logic                  match;
  logic                  out_free;
  logic [WORD_WIDTH-1:0] in_value;
  logic [WORD_WIDTH-1:0] cell_data [DEPTH];
  cell_op_e              cell_op [DEPTH];

  assign in_value  = WORD_WIDTH'(in_word_i.value);
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign in_range  = (PW'(in_word_i.position) < PW'(count_q));
  assign step_last = (step_q == IW'(DEPTH - 1));
  assign step_held = (CW'(step_q) < count_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign match = is_search_q ? (!found_q && step_held && (cell_data[0] == key_q))
                             : (PW'(step_q) == PW'(pos_q));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_op[i] = shift_right ? OP_LOAD :
                          (load_back && count_q == CW'(i)) ? OP_LOAD :
                          shift_left ? OP_FROM_RIGHT : OP_HOLD;
    end else begin : g_body
      assign cell_op[i] = (load_back && count_q == CW'(i)) ? OP_LOAD :
                          shift_right ? OP_FROM_LEFT :
                          shift_left ? OP_FROM_RIGHT : OP_HOLD;
    end

    dwis_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[i]),
      .load_i (in_value),
      .left_i (cell_data[(i + DEPTH - 1) % DEPTH]),
      .right_i(cell_data[(i + 1) % DEPTH]),
      .data_o (cell_data[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    is_search_d = is_search_q;
    found_d     = found_q;
    key_d       = key_q;
    pos_d       = pos_q;
    hit_idx_d   = hit_idx_q;
    hit_word_d  = hit_word_q;
    load_back   = 1'b0;
    shift_right = 1'b0;
    shift_left  = 1'b0;
    res_load    = 1'b0;
    out_d       = out_q;

    out_d.status         = STATUS_OK;
    out_d.read_value     = '0;
    out_d.found_position = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_e'(in_word_i.cmd))
            CMD_PUSH_BACK: begin
              res_load = 1'b1;
              if (full) begin
                out_d.status = STATUS_FULL;
              end else begin
                load_back = 1'b1;
                count_d   = count_q + 1'b1;
              end
            end
            CMD_PUSH_FRONT: begin
              res_load = 1'b1;
              if (full) begin
                out_d.status = STATUS_FULL;
              end else begin
                shift_right = 1'b1;
                count_d     = count_q + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              res_load = 1'b1;
              if (empty) begin
                out_d.status = STATUS_EMPTY;
              end else begin
                shift_left = 1'b1;
                count_d    = count_q - 1'b1;
              end
            end
            CMD_POP_BACK: begin
              res_load = 1'b1;
              if (empty) begin
                out_d.status = STATUS_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            CMD_READ: begin
              if (!in_range) begin
                res_load     = 1'b1;
                out_d.status = STATUS_RANGE;
              end else begin
                state_d     = S_SCAN;
                step_d      = '0;
                is_search_d = 1'b0;
                found_d     = 1'b0;
                pos_d       = in_word_i.position;
              end
            end
            CMD_SEARCH: begin
              state_d     = S_SCAN;
              step_d      = '0;
              is_search_d = 1'b1;
              found_d     = 1'b0;
              key_d       = in_value;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        shift_left = 1'b1;
        step_d     = step_q + 1'b1;
        if (match) begin
          found_d    = 1'b1;
          hit_idx_d  = step_q;
          hit_word_d = cell_data[0];
        end
        if (step_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          if (is_search_q) begin
            if (found_q) begin
              out_d.found_position = POS_W'(hit_idx_q);
            end else begin
              out_d.status = STATUS_NOT_FOUND;
            end
          end else begin
            out_d.read_value = VALUE_W'(hit_word_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d.occupancy = OCC_W'(count_d);

    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q      <= step_d;
    is_search_q <= is_search_d;
    found_q     <= found_d;
    key_q       <= key_d;
    pos_q       <= pos_d;
    hit_idx_q   <= hit_idx_d;
    hit_word_q  <= hit_word_d;
    if (res_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Occupancy exceeds the depth.");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("Command taken while a rotation is running.");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(count_q))
    else $error("Occupancy changed without a command.");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && step_last) |=> state_q == S_DONE)
    else $error("Rotation did not end after a full turn.");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> state_q == S_DONE)
    else $error("Result overwrote a word still waiting at the output.");

endmodule

[bench/dwis_deque_checker.sv]
// Checker for the deque core: watches the command and result channels, keeps its own deque
// to predict each result word, and compares every accepted result with the oldest prediction.
// Depends on dwis_pkg.
module dwis_deque_checker import dwis_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  in_word_t    cmd_word_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  out_word_t   rsp_word_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [VALUE_W-1:0] ring_q [DEPTH];
  logic [POS_W-1:0]   head_q;
  logic [OCC_W-1:0]   fill_q;
  out_word_t          awaited_q [$];
  int unsigned        mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("dwis_deque_checker: at %0t %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t        r;
    logic [POS_W-1:0] slot;
    logic             hit;
    r = '0;
    r.status = STATUS_OK;
    hit = 1'b0;
    case (w.cmd)
      CMD_PUSH_BACK: begin
        if (fill_q == DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          slot = head_q + fill_q[POS_W-1:0];
          ring_q[slot] = w.value;
          fill_q = fill_q + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (fill_q == DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          head_q = head_q - 1'b1;
          ring_q[head_q] = w.value;
          fill_q = fill_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (fill_q == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          head_q = head_q + 1'b1;
          fill_q = fill_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (fill_q == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          fill_q = fill_q - 1'b1;
        end
      end
      CMD_READ: begin
        if (w.position >= fill_q) begin
          r.status = STATUS_RANGE;
        end else begin
          slot = head_q + w.position;
          r.read_value = ring_q[slot];
        end
      end
      CMD_SEARCH: begin
        r.status = STATUS_NOT_FOUND;
        for (int i = 0; i < DEPTH; i++) begin
          slot = head_q + POS_W'(i);
          if (!hit && i < fill_q && ring_q[slot] == w.value) begin
            hit = 1'b1;
            r.status = STATUS_OK;
            r.found_position = POS_W'(i);
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = fill_q;
    return r;
  endfunction

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (awaited_q.size() == 0) begin
      report_mismatch("result word with no command pending", 32'(got.occupancy), '0);
    end else begin
      want = awaited_q.pop_front();
      if (got.status != want.status) begin
        report_mismatch("status", 32'(got.status), 32'(want.status));
      end
      if (got.read_value != want.read_value) begin
        report_mismatch("read_value", got.read_value, want.read_value);
      end
      if (got.found_position != want.found_position) begin
        report_mismatch("found_position", 32'(got.found_position),
                        32'(want.found_position));
      end
      if (got.occupancy != want.occupancy) begin
        report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q = '0;
      fill_q = '0;
      awaited_q.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        check_result(rsp_word_i);
      end
      if (cmd_valid_i && cmd_ready_i) begin
        awaited_q.push_back(apply_command(cmd_word_i));
      end
    end
    pending_o = awaited_q.size();
  end

  final begin
    if (awaited_q.size() != 0) begin
      $display("dwis_deque_checker: %0d result words never arrived", awaited_q.size());
    end
  end

endmodule

[bench/tb_deque_with_index_and_search_core.sv]
// Testbench top for the deque core: drives directed and random command words in bursts,
// stalls the result side on its own pattern, and reports the verdict from the checker.
// Depends on dwis_pkg, deque_with_index_and_search_core and dwis_deque_checker.
module tb_deque_with_index_and_search_core;
  import dwis_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_WORDS = 750;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;
  typedef enum int {RX_OPEN, RX_CHOPPY, RX_LONG} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_word_o;
  int unsigned fail_count;
  int unsigned pending;

  logic [VALUE_W-1:0] value_pool [8];
  rx_mode_e           rx_mode = RX_OPEN;
  int                 rx_left = 0;
  int                 stall_run = 0;
  logic               rx_next;

  always #5 clk_i = ~clk_i;

  deque_with_index_and_search_core #(
    .DEPTH(DEPTH),
    .WORD_WIDTH(VALUE_W)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o(out_word_o)
  );

  dwis_deque_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cmd_valid_i(in_valid_i),
    .cmd_ready_i(in_ready_o),
    .cmd_word_i(in_word_i),
    .rsp_valid_i(out_valid_o),
    .rsp_ready_i(out_ready_i),
    .rsp_word_i(out_word_o),
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: rx_next = 1'b1;
      RX_CHOPPY: rx_next = ($urandom_range(0, 2) != 0);
      default: begin
        if (stall_run > 0) begin
          rx_next = 1'b0;
          stall_run--;
        end else begin
          rx_next = 1'b1;
          if ($urandom_range(0, 3) == 0) begin
            stall_run = $urandom_range(5, 20);
          end
        end
      end
    endcase
    out_ready_i <= rx_next;
  end

  task automatic send_cmd(input in_word_t w);
    logic taken;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                       input logic [POS_W-1:0] position);
    in_word_t w;
    w.cmd = cmd;
    w.value = value;
    w.position = position;
    send_cmd(w);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) begin
      return value_pool[$urandom_range(0, 7)];
    end else begin
      return $urandom();
    end
  endfunction

  function automatic in_word_t random_cmd(input mix_e mix);
    in_word_t    w;
    int unsigned roll;
    int unsigned side;
    int unsigned push_pct;
    int unsigned pop_pct;
    roll = $urandom_range(0, 99);
    side = $urandom_range(0, 1);
    w.value = pick_value();
    w.position = POS_W'($urandom_range(0, 15));
    case (mix)
      MIX_FILL: begin
        push_pct = 65;
        pop_pct = 10;
      end
      MIX_DRAIN: begin
        push_pct = 15;
        pop_pct = 55;
      end
      default: begin
        push_pct = 30;
        pop_pct = 30;
      end
    endcase
    if (roll < 2) begin
      w.cmd = side ? CMD_SPARE_HI : CMD_SPARE_LO;
    end else if (roll < 2 + push_pct) begin
      w.cmd = side ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else if (roll < 2 + push_pct + pop_pct) begin
      w.cmd = side ? CMD_POP_BACK : CMD_POP_FRONT;
    end else begin
      w.cmd = side ? CMD_SEARCH : CMD_READ;
    end
    return w;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned seg_left;
    mix_e        mix;
    for (int i = 0; i < 8; i++) begin
      value_pool[i] = $urandom();
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: both pops, a read and a search all fail.
    issue(CMD_POP_FRONT, '0, '0);
    issue(CMD_POP_BACK, '0, '0);
    issue(CMD_READ, '0, '0);
    issue(CMD_SEARCH, '0, '0);
    issue(CMD_PUSH_BACK, '1, '1);
    issue(CMD_PUSH_FRONT, '0, '0);
    issue(CMD_PUSH_BACK, 32'hA5A5_5A5A, '0);
    issue(CMD_READ, '0, 4'd0);
    issue(CMD_READ, '0, 4'd2);
    issue(CMD_READ, '0, 4'd3);
    issue(CMD_READ, '1, '1);
    issue(CMD_SEARCH, '1, '0);
    issue(CMD_SEARCH, '0, '1);
    issue(CMD_SEARCH, 32'h1234_5678, '0);
    issue(CMD_SPARE_LO, '1, '1);
    issue(CMD_SPARE_HI, 32'h5A5A_A5A5, 4'd5);
    issue(CMD_POP_BACK, '0, '0);
    issue(CMD_POP_FRONT, '0, '0);
    issue(CMD_POP_FRONT, '0, '0);
    issue(CMD_POP_FRONT, '0, '0);

    sent = 0;
    seg_left = 0;
    mix = MIX_FILL;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        if (seg_left == 0) begin
          mix = mix_e'($urandom_range(0, 2));
          seg_left = $urandom_range(20, 60);
        end
        send_cmd(random_cmd(mix));
        sent++;
        seg_left--;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * DEPTH) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_deque_with_index_and_search_core: done, clean");
    end else begin
      $display("tb_deque_with_index_and_search_core: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_deque_with_index_and_search_core: done, errors");
    $finish;
  end

endmodule
